// ===== rtl/bgpe_pkg.sv =====
package bgpe_pkg;

    // Default sizes of the glyph store and of the largest font
    localparam int DEF_MAX_GLYPHS = 256;
    localparam int DEF_MAX_ROWS   = 8;
    localparam int DEF_MAX_COLS   = 8;

    // One glyph row is an 8-bit bitmap, bit 7 leftmost
    localparam int GLYPH_BITS = 8;

    // Store address as carried in the queue; wide enough for the largest store
    localparam int STORE_ADDR_W = 13;

    // Front-to-back command queue
    localparam int QUEUE_DEPTH = 2;

    // APB port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register reset values
    localparam logic [31:0] FRAME_BASE_RST  = 32'd0;
    localparam logic [15:0] ROW_PITCH_RST   = 16'd4096;
    localparam logic [3:0]  FONT_WIDTH_RST  = 4'd8;
    localparam logic [3:0]  FONT_HEIGHT_RST = 4'd8;
    localparam logic [8:0]  GLYPH_COUNT_RST = 9'd256;

    typedef enum logic [2:0] {
        REG_FRAME_BASE  = 3'd0,
        REG_ROW_PITCH   = 3'd1,
        REG_FONT_WIDTH  = 3'd2,
        REG_FONT_HEIGHT = 3'd3,
        REG_GLYPH_COUNT = 3'd4
    } reg_idx_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_DRAW = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] char_code;
        logic [7:0]  column;
        logic [7:0]  text_row;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [7:0]  load_glyph;
        logic [2:0]  load_row;
        logic [7:0]  load_bits;
    } req_t;

    typedef struct packed {
        logic [31:0] pixel_address;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } pix_t;

    // Live configuration, width and height already clamped to the legal range
    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] row_pitch;
        logic [3:0]  width;
        logic [3:0]  height;
        logic [8:0]  glyph_count;
    } cfg_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic                    is_draw;
        logic [STORE_ADDR_W-1:0] addr;
        logic [GLYPH_BITS-1:0]   bits;
        logic [31:0]             origin;
        logic [31:0]             fg;
        logic [31:0]             bg;
    } cmd_t;

endpackage

// ===== rtl/bgpe_front.sv =====
module bgpe_front
    import bgpe_pkg::*;
#(
    parameter int MAX_GLYPHS = DEF_MAX_GLYPHS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  req_t req_word,
    input  logic req_valid,
    output logic req_ready,
    output cmd_t push_cmd,
    output logic push_valid,
    input  logic push_ready
);

    logic                    a_vld_reg;
    logic                    a_vld_next;
    logic                    a_draw_reg;
    logic                    a_keep_reg;
    logic [STORE_ADDR_W-1:0] a_addr_reg;
    logic [GLYPH_BITS-1:0]   a_bits_reg;
    logic [31:0]             a_fg_reg;
    logic [31:0]             a_bg_reg;
    logic [11:0]             a_trow_h_reg;
    logic [11:0]             a_col_off_reg;

    logic                    accept;
    logic                    a_done;
    logic                    is_draw;
    logic                    glyph_ok;
    logic                    load_ok;
    logic [15:0]             glyph_sel;
    logic [STORE_ADDR_W-1:0] draw_base;
    logic [STORE_ADDR_W-1:0] load_addr;
    logic [11:0]             trow_h;
    logic [11:0]             col_off;
    logic [27:0]             row_off;

    // Classify the incoming word
    always_comb
    begin
        is_draw   = (req_word.req_type == REQ_DRAW);
        glyph_ok  = (req_word.char_code != 16'd0)
                 && (32'(req_word.char_code) < 32'(cfg.glyph_count))
                 && (32'(req_word.char_code) < 32'(MAX_GLYPHS));
        glyph_sel = glyph_ok ? req_word.char_code : 16'd0;
        draw_base = STORE_ADDR_W'(32'(glyph_sel) * 32'(MAX_ROWS));
        load_ok   = (32'(req_word.load_glyph) < 32'(MAX_GLYPHS))
                 && (32'(req_word.load_row) < 32'(MAX_ROWS));
        load_addr = STORE_ADDR_W'(32'(req_word.load_glyph) * 32'(MAX_ROWS)
                                  + 32'(req_word.load_row));
        trow_h    = {4'd0, req_word.text_row} * {8'd0, cfg.height};
        col_off   = {4'd0, req_word.column} * ({8'd0, cfg.width} + 12'd1);
    end

    // Out-of-range loads retire here without entering the queue
    assign a_done     = a_vld_reg && (!a_keep_reg || push_ready);
    assign req_ready  = !a_vld_reg || a_done;
    assign accept     = req_valid && req_ready;
    assign a_vld_next = accept ? 1'b1 : (a_done ? 1'b0 : a_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_draw_reg    <= is_draw;
            a_keep_reg    <= is_draw || load_ok;
            a_addr_reg    <= is_draw ? draw_base : load_addr;
            a_bits_reg    <= req_word.load_bits;
            a_fg_reg      <= req_word.fg_color;
            a_bg_reg      <= req_word.bg_color;
            a_trow_h_reg  <= trow_h;
            a_col_off_reg <= col_off;
        end
    end

    // Cell origin: base + text_row*h*pitch + column*(w+1)*4, mod 2^32
    assign row_off = {16'd0, a_trow_h_reg} * {12'd0, cfg.row_pitch};

    always_comb
    begin
        push_cmd.is_draw = a_draw_reg;
        push_cmd.addr    = a_addr_reg;
        push_cmd.bits    = a_bits_reg;
        push_cmd.origin  = cfg.frame_base + {4'd0, row_off}
                         + {18'd0, a_col_off_reg, 2'b00};
        push_cmd.fg      = a_fg_reg;
        push_cmd.bg      = a_bg_reg;
    end

    assign push_valid = a_vld_reg && a_keep_reg;

endmodule

// ===== rtl/bgpe_queue.sv =====
module bgpe_queue
    import bgpe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_cmd,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t head_cmd,
    output logic head_valid,
    input  logic pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr;
    logic             rd;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    assign wr = push_valid && push_ready;
    assign rd = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr) - CNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/bgpe_back.sv =====
module bgpe_back
    import bgpe_pkg::*;
#(
    parameter int MAX_GLYPHS = DEF_MAX_GLYPHS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t head_cmd,
    input  logic head_valid,
    output logic pop,
    output pix_t pix_word,
    output logic pix_valid,
    input  logic pix_ready
);

    localparam int STORE_DEPTH = MAX_GLYPHS * MAX_ROWS;
    localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XW          = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [GLYPH_BITS-1:0] store_mem [STORE_DEPTH];
    logic [GLYPH_BITS-1:0] rd_data_reg;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [SA_W-1:0]       base_reg;
    logic [SA_W-1:0]       base_next;
    logic [31:0]           line_reg;
    logic [31:0]           line_next;
    logic [31:0]           addr_reg;
    logic [31:0]           addr_next;
    logic [31:0]           fg_reg;
    logic [31:0]           fg_next;
    logic [31:0]           bg_reg;
    logic [31:0]           bg_next;
    logic [XW-1:0]         x_reg;
    logic [XW-1:0]         x_next;
    logic [YW-1:0]         y_reg;
    logic [YW-1:0]         y_next;
    logic [GLYPH_BITS-1:0] row_bits_reg;
    logic [GLYPH_BITS-1:0] row_bits_next;
    pix_t                  pix_word_reg;
    pix_t                  pix_word_next;
    logic                  pix_valid_reg;
    logic                  pix_valid_next;

    logic                  mem_we;
    logic                  mem_re;
    logic [SA_W-1:0]       mem_raddr;
    logic                  fire;
    logic                  row_end;
    logic                  last_row;
    logic [2:0]            bit_idx;

    assign fire     = (state_reg == BK_EMIT) && (!pix_valid_reg || pix_ready);
    assign row_end  = (4'(x_reg) == cfg.width - 4'd1);
    assign last_row = (4'(y_reg) == cfg.height - 4'd1);
    assign bit_idx  = 3'(GLYPH_BITS - 1) - 3'(x_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && head_cmd.is_draw)
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (fire && row_end)
                begin
                    if (last_row)
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (x_reg == '0)
                    begin
                        // one-pixel rows: next row read was issued this cycle
                        state_next = BK_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = base_reg;
        base_next      = base_reg;
        line_next      = line_reg;
        addr_next      = addr_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        row_bits_next  = row_bits_reg;
        pix_word_next  = pix_word_reg;
        pix_valid_next = pix_valid_reg && !pix_ready;

        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_cmd.is_draw)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = head_cmd.addr[SA_W-1:0];
                        base_next = head_cmd.addr[SA_W-1:0];
                        line_next = head_cmd.origin;
                        addr_next = head_cmd.origin;
                        fg_next   = head_cmd.fg;
                        bg_next   = head_cmd.bg;
                        x_next    = '0;
                        y_next    = '0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            BK_LOAD:
            begin
                row_bits_next = rd_data_reg;
            end
            BK_EMIT:
            begin
                if (fire)
                begin
                    pix_valid_next              = 1'b1;
                    pix_word_next.pixel_address = addr_reg;
                    pix_word_next.pixel_color   = row_bits_reg[bit_idx] ? fg_reg : bg_reg;
                    pix_word_next.last_pixel    = row_end && last_row;

                    // prefetch the next glyph row on the first pixel of a row
                    if ((x_reg == '0) && !last_row)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = base_reg + SA_W'(y_reg) + SA_W'(1);
                    end

                    if (row_end)
                    begin
                        x_next        = '0;
                        y_next        = y_reg + YW'(1);
                        line_next     = line_reg + {16'd0, cfg.row_pitch};
                        addr_next     = line_reg + {16'd0, cfg.row_pitch};
                        row_bits_next = rd_data_reg;
                    end
                    else
                    begin
                        x_next    = x_reg + XW'(1);
                        addr_next = addr_reg + 32'd4;
                    end
                end
            end
            default:
            begin
                pix_valid_next = 1'b0;
            end
        endcase
    end

    // Glyph store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[head_cmd.addr[SA_W-1:0]] <= head_cmd.bits;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        line_reg     <= line_next;
        addr_reg     <= addr_next;
        fg_reg       <= fg_next;
        bg_reg       <= bg_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        row_bits_reg <= row_bits_next;
        pix_word_reg <= pix_word_next;
    end

    assign pix_word  = pix_word_reg;
    assign pix_valid = pix_valid_reg;

endmodule

// ===== rtl/bitmap_glyph_pixel_expander.sv =====
// Bitmap glyph pixel expander: a text-mode character generator.
// Request channel (req_valid/req_ready/req_word): a load word writes one
// 8-bit glyph row into the glyph store and yields nothing; a draw word
// expands one glyph into w*h pixel words, row by row, left to right.
// Pixel channel (pix_valid/pix_ready/pix_word): one framebuffer write per
// word, last_pixel set on the final pixel of a character.
// APB port: frame_base, row_pitch, font_width, font_height, glyph_count at
// byte offsets 0, 4, 8, 12, 16; the user must see that they are written
// only while the block is idle, as the block does not enforce it. A draw
// word passes the front register, a queue slot, the glyph read, the row
// latch and the pixel register. Pixels then follow one per cycle unless
// pix_ready stalls, set by the single glyph-store read port; a font one
// pixel wide passes the load state again for each row after the first.
// A load is written in the idle state. The front keeps taking words while
// the back end draws, until the two-entry queue fills.
// A stall on pix_ready freezes the pixel sequencer; the request side then
// stops once the queue and front register are full.
// Reset clears control state and restores register defaults; the glyph
// store is not cleared and must be loaded before use.
module bitmap_glyph_pixel_expander
    import bgpe_pkg::*;
#(
    parameter int MAX_GLYPHS = DEF_MAX_GLYPHS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request words
    input  req_t               req_word,
    input  logic               req_valid,
    output logic               req_ready,
    // pixel words
    output pix_t               pix_word,
    output logic               pix_valid,
    input  logic               pix_ready,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [31:0] frame_base_reg;
    logic [15:0] row_pitch_reg;
    logic [3:0]  font_width_reg;
    logic [3:0]  font_height_reg;
    logic [8:0]  glyph_count_reg;

    logic        cfg_wr;
    logic [2:0]  reg_sel;
    cfg_t        cfg;

    cmd_t        push_cmd;
    logic        push_valid;
    logic        push_ready;
    cmd_t        head_cmd;
    logic        head_valid;
    logic        pop;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg  <= FRAME_BASE_RST;
            row_pitch_reg   <= ROW_PITCH_RST;
            font_width_reg  <= FONT_WIDTH_RST;
            font_height_reg <= FONT_HEIGHT_RST;
            glyph_count_reg <= GLYPH_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_FRAME_BASE:  frame_base_reg  <= pwdata;
                REG_ROW_PITCH:   row_pitch_reg   <= pwdata[15:0];
                REG_FONT_WIDTH:  font_width_reg  <= pwdata[3:0];
                REG_FONT_HEIGHT: font_height_reg <= pwdata[3:0];
                REG_GLYPH_COUNT: glyph_count_reg <= pwdata[8:0];
                default:         ;  // unmapped offsets ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_BASE:  prdata = frame_base_reg;
            REG_ROW_PITCH:   prdata = {16'd0, row_pitch_reg};
            REG_FONT_WIDTH:  prdata = {28'd0, font_width_reg};
            REG_FONT_HEIGHT: prdata = {28'd0, font_height_reg};
            REG_GLYPH_COUNT: prdata = {23'd0, glyph_count_reg};
            default:         prdata = '0;
        endcase
    end

    // Clamp font dimensions: 0 acts as 1, above the maximum saturates
    always_comb
    begin
        cfg.frame_base  = frame_base_reg;
        cfg.row_pitch   = row_pitch_reg;
        cfg.glyph_count = glyph_count_reg;

        if (font_width_reg == 4'd0)
            cfg.width = 4'd1;
        else if (font_width_reg > 4'(MAX_COLS))
            cfg.width = 4'(MAX_COLS);
        else
            cfg.width = font_width_reg;

        if (font_height_reg == 4'd0)
            cfg.height = 4'd1;
        else if (font_height_reg > 4'(MAX_ROWS))
            cfg.height = 4'(MAX_ROWS);
        else
            cfg.height = font_height_reg;
    end

    // ---------------- front: accept and classify ----------------
    bgpe_front #(
        .MAX_GLYPHS (MAX_GLYPHS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_word   (req_word),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // ---------------- command queue ----------------
    bgpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // ---------------- back: glyph store and pixel sequencer ----------------
    bgpe_back #(
        .MAX_GLYPHS (MAX_GLYPHS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .pix_word   (pix_word),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready)
    );

endmodule

// ===== rtl/bgpe_checker.sv =====
module bgpe_checker
    import bgpe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input req_t               req_word,
    input logic               req_valid,
    input logic               req_ready,
    input pix_t               pix_word,
    input logic               pix_valid,
    input logic               pix_ready,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    localparam logic [PADDR_W-1:0] ADDR_BASE  = PADDR_W'(4 * int'(REG_FRAME_BASE));
    localparam logic [PADDR_W-1:0] ADDR_WIDTH = PADDR_W'(4 * int'(REG_FONT_WIDTH));

    // no pixel word is offered in the cycle after reset is seen
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !pix_valid)
        else $error("pixel word offered during reset");

    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid)
        else $error("pixel word dropped while stalled");

    a_pix_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> $stable(pix_word))
        else $error("pixel word changed while stalled");

    // frame_base reads back what was just written
    a_base_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == ADDR_BASE)
        ##1 (psel && !pwrite && paddr == ADDR_BASE)
        |-> prdata == $past(pwdata))
        else $error("frame_base readback mismatch");

    // font_width keeps only its four bits
    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == ADDR_WIDTH)
        ##1 (psel && !pwrite && paddr == ADDR_WIDTH)
        |-> prdata == {28'd0, $past(pwdata[3:0])})
        else $error("font_width readback mismatch");

endmodule

bind bitmap_glyph_pixel_expander bgpe_checker u_bgpe_checker (.*);
